// ===== hdl/i2cmbe_pkg.sv =====
// Package for the I2C master bit engine: sequencer step codes, transfer
// modes, command and error codes, and the state and flag structs.
// No dependencies.
package i2cmbe_pkg;

   // Command codes carried by a request transaction
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // Error codes reported with done
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BUS     = 2'd1;
   localparam logic [1:0] ERR_NAK     = 2'd2;
   localparam logic [1:0] ERR_TIMEOUT = 2'd3;

   localparam logic [7:0] TIMEOUT_RESET = 8'd100;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam int         CHAIN_LEN     = 6;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_START_SDA, S_START_SCL, S_ADDR, S_WSETUP, S_WBIT,
      S_WWAIT, S_WCLK, S_ACK_REL, S_ACK_CLK, S_ACK_GET, S_ACK_FIN,
      S_STOP, S_STOP_REL, S_STOP_WAIT, S_RSETUP, S_RCLK, S_RBIT,
      S_GEN_ACK, S_GEN_NAK, S_GEN_CLK, S_GEN_DONE
   } step_type;

   typedef struct packed {
      step_type   step;
      mode_type   mode;
      logic [7:0] shreg;
      logic [3:0] bitc;
      logic [7:0] bp;
      logic [7:0] total;
      logic [6:0] addr;
      logic       ack;
      logic       tmo;
      logic [7:0] wait_cnt;
      logic       sda;
      logic       scl;
   } state_type;

   typedef struct packed {
      logic       again;
      logic       done;
      logic [1:0] code;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } flags_type;

endpackage

// ===== hdl/i2cmbe_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle,
// read-first. Depends on nothing.
module i2cmbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/i2cmbe_step.sv =====
// One sequencer step of the bit engine; the top level chains several of
// these per tick. Depends on i2cmbe_pkg.
module i2cmbe_step #(
   parameter int TX_DEPTH = 256
) (
   input  logic                  active,
   input  i2cmbe_pkg::state_type st_in,
   input  logic                  sda,
   input  logic                  scl,
   input  logic [7:0]            tx_byte,
   input  logic [7:0]            limit,
   output i2cmbe_pkg::state_type st_out,
   output i2cmbe_pkg::flags_type flags
);
   import i2cmbe_pkg::*;

   logic [3:0] bitc_inc;
   logic [7:0] bp_inc;
   logic [7:0] sh_rx;

   assign bitc_inc = st_in.bitc + 4'd1;
   assign bp_inc   = st_in.bp + 8'd1;
   assign sh_rx    = {st_in.shreg[6:0], sda};

   always_comb begin
      st_out = st_in;
      flags  = '0;
      if (active) begin
         case (st_in.step)
            S_IDLE: begin
               st_out.sda = 1'b1;
               st_out.scl = 1'b1;
               if (st_in.mode != MODE_IDLE) begin
                  st_out.wait_cnt = '0;
                  st_out.bitc     = '0;
                  st_out.bp       = '0;
                  st_out.tmo      = 1'b0;
                  st_out.step     = S_CHECK;
               end
            end
            S_CHECK: begin
               flags.again = 1'b1;
               if (sda && scl) begin
                  st_out.step = S_START_SDA;
               end else begin
                  flags.done  = 1'b1;
                  flags.code  = ERR_BUS;
                  st_out.mode = MODE_IDLE;
                  st_out.step = S_IDLE;
               end
            end
            S_START_SDA: begin
               st_out.sda  = 1'b0;
               st_out.step = S_START_SCL;
            end
            S_START_SCL: begin
               if (scl) begin
                  st_out.scl  = 1'b0;
                  st_out.step = S_ADDR;
               end else begin
                  st_out.sda  = 1'b1;
                  flags.again = 1'b1;
                  flags.done  = 1'b1;
                  flags.code  = ERR_BUS;
                  st_out.mode = MODE_IDLE;
                  st_out.step = S_IDLE;
               end
            end
            S_ADDR: begin
               st_out.shreg = {st_in.addr, st_in.mode == MODE_READ};
               st_out.bitc  = '0;
               st_out.step  = S_WBIT;
               flags.again  = 1'b1;
            end
            S_WSETUP: begin
               st_out.shreg = (int'(st_in.bp) < TX_DEPTH) ? tx_byte : 8'd0;
               st_out.bp    = bp_inc;
               st_out.bitc  = '0;
               st_out.step  = S_WBIT;
               flags.again  = 1'b1;
            end
            S_WBIT: begin
               st_out.sda   = st_in.shreg[7];
               st_out.shreg = {st_in.shreg[6:0], 1'b0};
               st_out.bitc  = bitc_inc;
               st_out.scl   = 1'b1;
               st_out.step  = S_WWAIT;
            end
            S_WWAIT: begin
               if (scl) begin
                  st_out.step = S_WCLK;
                  flags.again = 1'b1;
               end
            end
            S_WCLK: begin
               st_out.scl = 1'b0;
               if (st_in.bitc < BITS_PER_BYTE) begin
                  st_out.step = S_WBIT;
               end else begin
                  st_out.sda  = 1'b1;
                  st_out.step = S_ACK_REL;
               end
            end
            S_ACK_REL: begin
               st_out.wait_cnt = '0;
               st_out.scl      = 1'b1;
               st_out.step     = S_ACK_CLK;
            end
            S_ACK_CLK: begin
               if (scl) begin
                  st_out.step = S_ACK_GET;
                  flags.again = 1'b1;
               end else if (st_in.wait_cnt >= limit) begin
                  st_out.tmo  = 1'b1;
                  st_out.step = S_STOP;
               end else begin
                  st_out.wait_cnt = st_in.wait_cnt + 8'd1;
               end
            end
            S_ACK_GET: begin
               st_out.ack  = !sda;
               st_out.scl  = 1'b0;
               st_out.step = S_ACK_FIN;
            end
            S_ACK_FIN: begin
               if (st_in.ack && (st_in.bp < st_in.total)) begin
                  st_out.step = (st_in.mode == MODE_WRITE) ? S_WSETUP : S_RSETUP;
               end else begin
                  st_out.step = S_STOP;
                  flags.again = 1'b1;
               end
            end
            S_STOP: begin
               st_out.sda  = 1'b0;
               st_out.scl  = 1'b1;
               st_out.step = S_STOP_REL;
            end
            S_STOP_REL: begin
               st_out.sda  = 1'b1;
               st_out.step = S_STOP_WAIT;
            end
            S_STOP_WAIT: begin
               if (sda || (st_in.wait_cnt >= limit)) begin
                  flags.again = 1'b1;
                  flags.done  = 1'b1;
                  if (!sda || st_in.tmo) begin
                     flags.code = ERR_TIMEOUT;
                  end else begin
                     flags.code = st_in.ack ? ERR_NONE : ERR_NAK;
                  end
                  st_out.mode = MODE_IDLE;
                  st_out.step = S_IDLE;
               end else begin
                  st_out.wait_cnt = st_in.wait_cnt + 8'd1;
               end
            end
            S_RSETUP: begin
               st_out.shreg = '0;
               st_out.bitc  = '0;
               st_out.step  = S_RCLK;
            end
            S_RCLK: begin
               st_out.scl  = 1'b1;
               st_out.step = S_RBIT;
            end
            S_RBIT: begin
               st_out.shreg = sh_rx;
               st_out.bitc  = bitc_inc;
               st_out.scl   = 1'b0;
               if (bitc_inc < BITS_PER_BYTE) begin
                  st_out.step = S_RCLK;
               end else begin
                  flags.rx_valid = 1'b1;
                  flags.rx_byte  = sh_rx;
                  st_out.bp      = bp_inc;
                  st_out.step    = (bp_inc < st_in.total) ? S_GEN_ACK : S_GEN_NAK;
               end
            end
            S_GEN_ACK: begin
               st_out.sda  = 1'b0;
               st_out.scl  = 1'b1;
               st_out.step = S_GEN_CLK;
            end
            S_GEN_NAK: begin
               st_out.sda  = 1'b1;
               st_out.scl  = 1'b1;
               st_out.step = S_GEN_CLK;
            end
            S_GEN_CLK: begin
               st_out.scl  = 1'b0;
               st_out.step = S_GEN_DONE;
            end
            S_GEN_DONE: begin
               st_out.scl = 1'b0;
               if (st_in.bp < st_in.total) begin
                  st_out.sda  = 1'b1;
                  st_out.step = S_RSETUP;
               end else begin
                  st_out.sda  = 1'b0;
                  st_out.step = S_STOP;
               end
            end
            default: begin
               st_out.step = S_IDLE;
               flags.again = 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== hdl/i2c_master_bit_engine_unit.sv =====
// Top level of the I2C master bit engine: request decode, transmit store,
// step chain, and output register with skid stage.
// Depends on i2cmbe_pkg, i2cmbe_ram and i2cmbe_step.
//
//   channel  direction  ports                       handshake
//   req      in         req_func .. req_load_byte   req_valid / req_stall
//   rsp      out        rsp_sda_drive .. rsp_rx_byte rsp_valid / rsp_stall
//   csr      in         csr_wr_data                 csr_wr_en
//
// One transaction per cycle while req_stall is low; each request gives one
// registered response. A stalled response is held in the output register
// while a skid register takes one more request; req_stall rises only when
// both full. A tick runs up to six chained sequencer steps in its own cycle.
// Reset is synchronous and needs no clearing pass.
module i2c_master_bit_engine_unit #(
   parameter int TX_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic       req_sda_in,
   input  logic       req_scl_in,
   input  logic [6:0] req_slave_addr,
   input  logic [7:0] req_byte_count,
   input  logic [7:0] req_load_index,
   input  logic [7:0] req_load_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sda_drive,
   output logic       rsp_scl_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [1:0] rsp_error_code,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import i2cmbe_pkg::*;

   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   typedef struct packed {
      logic       sda;
      logic       scl;
      logic       busy;
      logic       done;
      logic [1:0] code;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } rsp_type;

   state_type  st_ff, st_in;
   logic [7:0] limit_ff;
   rsp_type    out_ff, skid_ff, res;
   logic       out_valid_ff, skid_valid_ff;
   logic       accept, take;
   logic       wr_en, byp_ff;
   logic [7:0] byp_data_ff, ram_rd, tx_byte;
   logic [AW-1:0] byp_addr_ff;
   state_type  chain_st [CHAIN_LEN+1];
   flags_type  chain_fl [CHAIN_LEN];
   logic       chain_act [CHAIN_LEN+1];
   flags_type  fl_all;

   assign accept = req_valid && !req_stall;
   assign take   = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign wr_en  = accept && (req_func == FUNC_LOAD) && (int'(req_load_index) < TX_DEPTH);

   // transmit store, read ahead at the next byte pointer
   i2cmbe_ram #(.WIDTH(8), .DEPTH(TX_DEPTH), .AW(AW)) u_tx_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_load_index[AW-1:0]),
      .wr_data (req_load_byte),
      .rd_addr (st_in.bp[AW-1:0]),
      .rd_data (ram_rd)
   );

   // forward a load that landed on the prefetched entry last cycle
   assign tx_byte = (byp_ff && (byp_addr_ff == st_ff.bp[AW-1:0])) ? byp_data_ff : ram_rd;

   // step chain for one tick
   assign chain_st[0]  = st_ff;
   assign chain_act[0] = (req_func == FUNC_TICK) && (st_ff.mode != MODE_IDLE);
   for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
      i2cmbe_step #(.TX_DEPTH(TX_DEPTH)) u_step (
         .active  (chain_act[k]),
         .st_in   (chain_st[k]),
         .sda     (req_sda_in),
         .scl     (req_scl_in),
         .tx_byte (tx_byte),
         .limit   (limit_ff),
         .st_out  (chain_st[k+1]),
         .flags   (chain_fl[k])
      );
      assign chain_act[k+1] = chain_act[k] && chain_fl[k].again;
   end

   always_comb begin
      fl_all = '0;
      for (int k = 0; k < CHAIN_LEN; k++) begin
         fl_all = fl_all | chain_fl[k];
      end
   end

   // next state per request
   always_comb begin
      st_in = st_ff;
      if (accept) begin
         case (req_func)
            FUNC_TICK: st_in = chain_st[CHAIN_LEN];
            FUNC_LOAD: st_in = st_ff;
            FUNC_WRITE, FUNC_READ: begin
               if (st_ff.mode == MODE_IDLE) begin
                  st_in.addr  = req_slave_addr;
                  st_in.total = req_byte_count;
                  st_in.mode  = (req_func == FUNC_WRITE) ? MODE_WRITE : MODE_READ;
               end
            end
            default: st_in = st_ff;
         endcase
      end
   end

   // response fields from the new state
   always_comb begin
      res.sda      = st_in.sda;
      res.scl      = st_in.scl;
      res.busy     = st_in.mode != MODE_IDLE;
      res.done     = 1'b0;
      res.code     = ERR_NONE;
      res.rx_valid = 1'b0;
      res.rx_byte  = '0;
      if (req_func == FUNC_TICK) begin
         res.done     = fl_all.done;
         res.code     = fl_all.code;
         res.rx_valid = fl_all.rx_valid;
         res.rx_byte  = fl_all.rx_byte;
      end
   end

   // state, configuration and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '{step: S_IDLE, mode: MODE_IDLE, sda: 1'b1, scl: 1'b1,
                            default: '0};
         limit_ff      <= TIMEOUT_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         byp_ff        <= 1'b0;
      end else begin
         st_ff  <= st_in;
         byp_ff <= wr_en;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            if (!out_valid_ff || take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byp_addr_ff <= req_load_index[AW-1:0];
      byp_data_ff <= req_load_byte;
      if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sda_drive  = out_ff.sda;
   assign rsp_scl_drive  = out_ff.scl;
   assign rsp_busy_res   = out_ff.busy;
   assign rsp_done_res   = out_ff.done;
   assign rsp_error_code = out_ff.code;
   assign rsp_rx_valid   = out_ff.rx_valid;
   assign rsp_rx_byte    = out_ff.rx_byte;

   // checks
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_busy_res))
      else $error("done reported while still busy");
   a_code_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_error_code == ERR_NONE))
      else $error("error code without done");
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output empty");
   a_rx_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_valid) |-> !rsp_done_res)
      else $error("received byte and done in one transaction");

endmodule

// ===== tb/i2c_master_bit_engine_unit_test.sv =====
// Self-checking testbench for the I2C master bit engine: a scoreboard class
// predicts every response from its own sequencer copy; tasks drive requests.
// Depends on i2cmbe_pkg and i2c_master_bit_engine_unit.
module i2c_master_bit_engine_unit_test;
   import i2cmbe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic       sda;
      logic       scl;
      logic       busy;
      logic       done;
      logic [1:0] err;
      logic       rxv;
      logic [7:0] rxb;
   } bus_result_type;

   // Sequencer copy plus the queue of responses still owed by the block
   class i2c_txn_scoreboard;
      step_type       step;
      mode_type       mode;
      logic [7:0]     shreg, bp, total, wait_cnt, limit;
      logic [3:0]     bitc;
      logic [6:0]     addr;
      logic           ack, tmo, sda_l, scl_l;
      logic [7:0]     store [256];
      bus_result_type cur;
      bus_result_type owed [$];
      int             fails;

      function new();
         step = S_IDLE; mode = MODE_IDLE; shreg = 0; bp = 0; total = 0;
         wait_cnt = 0; limit = TIMEOUT_RESET; bitc = 0; addr = 0;
         ack = 0; tmo = 0; sda_l = 1; scl_l = 1; fails = 0;
      endfunction

      function void end_xfer(logic [1:0] code);
         cur.done = 1; cur.err = code; mode = MODE_IDLE; step = S_IDLE;
      endfunction

      // Up to CHAIN_LEN chained steps per tick
      function void run_tick(logic sda, logic scl);
         logic again;
         for (int n = 0; n < CHAIN_LEN; n++) begin
            again = 0;
            case (step)
               S_IDLE: begin
                  sda_l = 1; scl_l = 1;
                  if (mode != MODE_IDLE) begin
                     wait_cnt = 0; bitc = 0; bp = 0; tmo = 0; step = S_CHECK;
                  end
               end
               S_CHECK: begin
                  if (sda && scl) step = S_START_SDA;
                  else end_xfer(ERR_BUS);
                  again = 1;
               end
               S_START_SDA: begin
                  sda_l = 0; step = S_START_SCL;
               end
               S_START_SCL: begin
                  if (scl) begin
                     scl_l = 0; step = S_ADDR;
                  end else begin
                     sda_l = 1; end_xfer(ERR_BUS); again = 1;
                  end
               end
               S_ADDR: begin
                  shreg = {addr, mode == MODE_READ};
                  bitc = 0; step = S_WBIT; again = 1;
               end
               S_WSETUP: begin
                  shreg = store[bp]; bp++; bitc = 0; step = S_WBIT; again = 1;
               end
               S_WBIT: begin
                  sda_l = shreg[7]; shreg = shreg << 1;
                  bitc++; scl_l = 1; step = S_WWAIT;
               end
               S_WWAIT: begin
                  if (scl) begin
                     step = S_WCLK; again = 1;
                  end
               end
               S_WCLK: begin
                  scl_l = 0;
                  if (bitc < BITS_PER_BYTE) step = S_WBIT;
                  else begin
                     sda_l = 1; step = S_ACK_REL;
                  end
               end
               S_ACK_REL: begin
                  wait_cnt = 0; scl_l = 1; step = S_ACK_CLK;
               end
               S_ACK_CLK: begin
                  if (scl) begin
                     step = S_ACK_GET; again = 1;
                  end else if (wait_cnt >= limit) begin
                     tmo = 1; step = S_STOP;
                  end else wait_cnt++;
               end
               S_ACK_GET: begin
                  ack = (sda == 0); scl_l = 0; step = S_ACK_FIN;
               end
               S_ACK_FIN: begin
                  if (ack && bp < total)
                     step = (mode == MODE_WRITE) ? S_WSETUP : S_RSETUP;
                  else begin
                     step = S_STOP; again = 1;
                  end
               end
               S_STOP: begin
                  sda_l = 0; scl_l = 1; step = S_STOP_REL;
               end
               S_STOP_REL: begin
                  sda_l = 1; step = S_STOP_WAIT;
               end
               S_STOP_WAIT: begin
                  if (sda) begin
                     end_xfer(tmo ? ERR_TIMEOUT : (ack ? ERR_NONE : ERR_NAK));
                     again = 1;
                  end else if (wait_cnt >= limit) begin
                     end_xfer(ERR_TIMEOUT); again = 1;
                  end else wait_cnt++;
               end
               S_RSETUP: begin
                  shreg = 0; bitc = 0; step = S_RCLK;
               end
               S_RCLK: begin
                  scl_l = 1; step = S_RBIT;
               end
               S_RBIT: begin
                  shreg = {shreg[6:0], sda}; bitc++; scl_l = 0;
                  if (bitc < BITS_PER_BYTE) step = S_RCLK;
                  else begin
                     cur.rxv = 1; cur.rxb = shreg; bp++;
                     step = (bp < total) ? S_GEN_ACK : S_GEN_NAK;
                  end
               end
               S_GEN_ACK: begin
                  sda_l = 0; scl_l = 1; step = S_GEN_CLK;
               end
               S_GEN_NAK: begin
                  sda_l = 1; scl_l = 1; step = S_GEN_CLK;
               end
               S_GEN_CLK: begin
                  scl_l = 0; step = S_GEN_DONE;
               end
               S_GEN_DONE: begin
                  scl_l = 0; sda_l = 1;
                  if (bp < total) step = S_RSETUP;
                  else begin
                     sda_l = 0; step = S_STOP;
                  end
               end
               default: begin
                  step = S_IDLE; again = 1;
               end
            endcase
            if (!again) break;
         end
      endfunction

      // Accepted request: advance the copy and queue the response it owes
      function void note_request(logic [1:0] f, logic sda, logic scl, logic [6:0] a,
                                 logic [7:0] cnt, logic [7:0] li, logic [7:0] lb);
         cur = '{default: 0};
         if (f == FUNC_TICK) begin
            if (mode != MODE_IDLE) run_tick(sda, scl);
         end else if (f == FUNC_LOAD) begin
            store[li] = lb;
         end else if (mode == MODE_IDLE) begin
            addr = a; total = cnt;
            mode = (f == FUNC_WRITE) ? MODE_WRITE : MODE_READ;
         end
         cur.sda = sda_l; cur.scl = scl_l; cur.busy = (mode != MODE_IDLE);
         owed.push_back(cur);
      endfunction

      function void cmp(string name, int e, int a);
         if (e != a) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
            fails++;
         end
      endfunction

      function void check_response(bus_result_type act);
         bus_result_type e;
         if (owed.size() == 0) begin
            $display("%0t: response with nothing expected", $time);
            fails++;
            return;
         end
         e = owed.pop_front();
         cmp("sda_drive", e.sda, act.sda);
         cmp("scl_drive", e.scl, act.scl);
         cmp("busy_res", e.busy, act.busy);
         cmp("done_res", e.done, act.done);
         cmp("error_code", e.err, act.err);
         cmp("rx_valid", e.rxv, act.rxv);
         cmp("rx_byte", e.rxb, act.rxb);
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [1:0] req_func = FUNC_TICK;
   logic       req_sda_in = 1;
   logic       req_scl_in = 1;
   logic [6:0] req_slave_addr = 0;
   logic [7:0] req_byte_count = 0;
   logic [7:0] req_load_index = 0;
   logic [7:0] req_load_byte = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic       rsp_sda_drive, rsp_scl_drive, rsp_busy_res, rsp_done_res, rsp_rx_valid;
   logic [1:0] rsp_error_code;
   logic [7:0] rsp_rx_byte;
   logic       csr_wr_en = 0;
   logic [7:0] csr_wr_data = 0;

   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycles = 0;
   i2c_txn_scoreboard sb = new();

   i2c_master_bit_engine_unit u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: check accepted transactions, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_sda_drive, rsp_scl_drive, rsp_busy_res, rsp_done_res,
                             rsp_error_code, rsp_rx_valid, rsp_rx_byte});
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_request(logic [1:0] f, logic sda, logic scl, logic [6:0] a,
                               logic [7:0] cnt, logic [7:0] li, logic [7:0] lb);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_func <= f; req_sda_in <= sda; req_scl_in <= scl;
      req_slave_addr <= a; req_byte_count <= cnt; req_load_index <= li;
      req_load_byte <= lb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(f, sda, scl, a, cnt, li, lb);
   endtask

   // Drop valid and wait for every owed response to drain
   task automatic drain_responses();
      req_valid <= 0;
      @(posedge clock);
      while (sb.owed.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(logic [7:0] v);
      csr_wr_en <= 1; csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.limit = v;
   endtask

   // Bus levels shaped by where the sequencer is, so transfers get deep
   task automatic random_tick();
      logic sda, scl;
      scl = ($urandom_range(99) < 88);
      case (sb.step)
         S_IDLE, S_CHECK, S_START_SDA, S_START_SCL: begin
            sda = ($urandom_range(99) < 94);
            scl = ($urandom_range(99) < 94);
         end
         S_ACK_REL, S_ACK_CLK, S_ACK_GET: sda = ($urandom_range(99) < 15);
         S_STOP_REL, S_STOP_WAIT: sda = ($urandom_range(99) < 80);
         default: sda = 1'($urandom_range(1));
      endcase
      send_request(FUNC_TICK, sda, scl, 7'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   task automatic random_request();
      int unsigned r;
      logic [7:0]  cnt;
      r = $urandom_range(99);
      if (sb.mode != MODE_IDLE && r < 93) begin
         random_tick();
         return;
      end
      if (sb.mode == MODE_IDLE && r < 20) begin
         random_tick();
         return;
      end
      if (r < 45 || r >= 97) begin
         send_request(FUNC_LOAD, 1'($urandom), 1'($urandom), 7'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
         return;
      end
      r = $urandom_range(99);
      cnt = (r < 85) ? 8'($urandom_range(4)) : (r < 98) ? 8'($urandom_range(16, 5)) : 8'd255;
      send_request($urandom_range(1) ? FUNC_WRITE : FUNC_READ, 1'($urandom), 1'($urandom),
                   7'($urandom), cnt, 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int unsigned limits [5] = '{8'd1, 8'd255, 8'd2, 8'd7, 8'd100};
      int unsigned gaps   [5] = '{0, 66, 0, 18, 0};
      int unsigned stalls [5] = '{0, 0, 66, 18, 0};

      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed: store extremes, idle tick, busy start ignored, bus-busy errors
      send_request(FUNC_LOAD, 0, 0, 0, 0, 8'd0, 8'h00);
      send_request(FUNC_LOAD, 1, 1, 0, 0, 8'd1, 8'hFF);
      send_request(FUNC_LOAD, 0, 1, 0, 0, 8'd255, 8'hA5);
      send_request(FUNC_LOAD, 1, 0, 0, 0, 8'd2, 8'h80);
      send_request(FUNC_TICK, 0, 0, 0, 0, 0, 0);
      send_request(FUNC_WRITE, 1, 1, 7'd127, 8'd2, 8'hFF, 8'hFF);
      send_request(FUNC_READ, 0, 0, 7'd0, 8'd255, 0, 0);
      send_request(FUNC_TICK, 1, 1, 0, 0, 0, 0);
      send_request(FUNC_TICK, 0, 1, 0, 0, 0, 0);
      send_request(FUNC_READ, 1, 1, 7'd0, 8'd1, 0, 0);
      send_request(FUNC_TICK, 1, 1, 0, 0, 0, 0);
      send_request(FUNC_TICK, 1, 1, 0, 0, 0, 0);
      send_request(FUNC_TICK, 1, 0, 0, 0, 0, 0);
      send_request(FUNC_WRITE, 1, 1, 7'h55, 8'd0, 0, 0);
      send_request(FUNC_TICK, 1, 0, 0, 0, 0, 0);
      send_request(FUNC_READ, 1, 1, 7'h2A, 8'd3, 0, 0);
      send_request(FUNC_TICK, 1, 1, 0, 0, 0, 0);

      // Fill the whole transmit store before random writes can reach it
      for (int i = 0; i < 256; i++)
         send_request(FUNC_LOAD, 1'($urandom), 1'($urandom), 7'($urandom), 8'($urandom),
                      8'(i), 8'($urandom));

      // Random phases with different timeouts and idling
      for (int p = 0; p < 5; p++) begin
         drain_responses();
         write_timeout(8'(limits[p]));
         gap_pct = gaps[p];
         stall_pct = stalls[p];
         for (int i = 0; i < 240; i++) random_request();
      end

      drain_responses();
      if (sb.fails == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
